[rtl/core/ascending_value_sorter_top_defines.svh]
// Assertion macros for the sorter top level.
`ifndef ASCENDING_VALUE_SORTER_TOP_DEFINES_SVH
`define ASCENDING_VALUE_SORTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define AVS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("avs assertion failed");
// Check a property on every clock edge, reset included.
`define AVS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("avs assertion failed");
`else
`define AVS_ASSERT(lbl, prop)
`define AVS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[rtl/core/avs_pkg.sv]
// Shared types and constants of the ascending value sorter.
package avs_pkg;

  localparam int VALUE_W       = 32;
  localparam int MAX_ITEMS_DEF = 64;

  typedef logic signed [VALUE_W-1:0] value_t;

  // What one cell shows its neighbours.
  typedef struct packed {
    logic   valid;
    logic   gt;
    value_t value;
  } link_t;

  // Chain-wide commands for the current cycle.
  typedef struct packed {
    logic ins;
    logic shift;
  } cmd_t;

endpackage

[rtl/core/avs_cell.sv]
// One cell of the insertion chain: holds one stored value in sorted position.
module avs_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  avs_pkg::cmd_t   cmd,
  input  avs_pkg::value_t new_value,
  input  avs_pkg::link_t  left,
  input  avs_pkg::link_t  right,
  output avs_pkg::link_t  own
);
  import avs_pkg::*;

  logic   valid_r;
  logic   valid_nxt;
  value_t value_r;
  value_t value_nxt;
  logic   gt;

  // An empty cell counts as larger than any incoming value.
  assign gt = !valid_r || (value_r > new_value);

  assign own = '{valid: valid_r, gt: gt, value: value_r};

  // Insert: take the left neighbour's value if it moves up, else the new one.
  // Shift: advance the right neighbour's value towards the output.
  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (cmd.shift) begin
      valid_nxt = right.valid;
      value_nxt = right.value;
    end else if (cmd.ins && gt) begin
      valid_nxt = left.gt ? left.valid : 1'b1;
      value_nxt = left.gt ? left.value : new_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

[rtl/core/ascending_value_sorter_top.sv]
// Top level of the ascending value sorter: insertion chain and drain control.
`include "ascending_value_sorter_top_defines.svh"

// Collects a set of signed 32-bit values, one request per cycle, into a chain
// of MAX_ITEMS cells that keeps them in ascending order as they arrive: every
// cell compares the incoming value with its own and the larger values move
// one cell along. The request that carries is_last is inserted too, then the
// block drains the chain from the smallest cell, one result per cycle while
// out_stall is low, and flags the final one with final_res. While draining,
// in_stall is high. The output pace is set by the one-step shift of the
// chain. Values that arrive while all cells are full are dropped.
module ascending_value_sorter_top #(
  parameter int MAX_ITEMS = avs_pkg::MAX_ITEMS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  avs_pkg::value_t in_value,
  input  logic            in_is_last,
  output logic            out_valid,
  input  logic            out_stall,
  output avs_pkg::value_t out_sorted_value,
  output logic            out_final_res
);
  import avs_pkg::*;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

  state_t state_r;
  state_t state_nxt;

  link_t                cell_link [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] valid_vec;
  logic [MAX_ITEMS-2:0] order_err;
  cmd_t                 cmd;
  logic                 in_acc;
  logic                 out_acc;
  logic                 full;

  localparam link_t HEAD_LINK = '{valid: 1'b1, gt: 1'b0, value: '0};
  localparam link_t TAIL_LINK = '{valid: 1'b0, gt: 1'b1, value: '0};

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign full    = valid_vec[MAX_ITEMS-1];

  // Insert when room remains, shift on each taken result.
  assign cmd = '{ins: in_acc && !full, shift: out_acc};

  // Build the chain.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    avs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .new_value (in_value),
      .left      ((i == 0) ? HEAD_LINK : cell_link[(i == 0) ? 0 : i-1]),
      .right     ((i == MAX_ITEMS-1) ? TAIL_LINK
                                     : cell_link[(i == MAX_ITEMS-1) ? i : i+1]),
      .own       (cell_link[i])
    );
    assign valid_vec[i] = cell_link[i].valid;
  end

  // Flag neighbours that are out of order.
  for (genvar i = 0; i < MAX_ITEMS-1; i++) begin : g_order
    assign order_err[i] = cell_link[i+1].valid &&
                          (cell_link[i].value > cell_link[i+1].value);
  end

  // Hold input back and present the head cell while draining.
  assign in_stall         = (state_r == ST_DRAIN);
  assign out_valid        = (state_r == ST_DRAIN) && cell_link[0].valid;
  assign out_sorted_value = cell_link[0].value;
  assign out_final_res    = !cell_link[1].valid;

  // Advance to drain on the last request, back to fill once emptied.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_FILL: begin
        if (in_acc && in_is_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_acc && out_final_res) state_nxt = ST_FILL;
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  `AVS_ASSERT(a_valid_packed, (valid_vec[MAX_ITEMS-1:1] & ~valid_vec[MAX_ITEMS-2:0]) == '0)
  `AVS_ASSERT(a_chain_sorted, order_err == '0)
  `AVS_ASSERT(a_drain_nonempty, (state_r == ST_DRAIN) |-> valid_vec[0])
  `AVS_ASSERT(a_final_reopens, (out_acc && out_final_res) |=> !in_stall && !valid_vec[0])
  `AVS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid)

endmodule
